/* rtl/lfid_pkg.sv */
// ----------------------------------------------------------------------------
// lfid_pkg: shared definitions of the lowest free identifier allocator
// Holds the bitmap word geometry, the default pool size, the status codes
// of a result and the first-set-bit search used on one bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

package lfid_pkg;

  // One bitmap word holds the free flags of this many slots.
  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = $clog2(WORD_BITS);

  localparam int DEFAULT_POOL_SIZE = 1024;

  localparam int OFFSET_W = 12;
  localparam int ID_W     = 16;

  typedef logic [2:0] status_t;

  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_EXHAUSTED = 3'd1;
  localparam status_t STATUS_RANGE     = 3'd2;
  localparam status_t STATUS_DOUBLE    = 3'd3;
  localparam status_t STATUS_RESERVED  = 3'd4;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_IDX_W-1:0] first_set(input map_word_t w);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/lfid_ram.sv */
// ----------------------------------------------------------------------------
// lfid_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module lfid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/lowest_free_id_allocator_top.sv */
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_top: lowest free identifier allocator
// Hands out slot numbers 1 to POOL_SIZE, each plus a configured offset, and
// takes them back. The free flags live in a bitmap RAM of 64-bit words; a
// register keeps the lowest free slot so that an allocation needs no search
// for itself, only for the slot that follows it.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_req_type, in_release_id
//   out_     output     out_valid/out_stall out_granted_id, out_status
//   cfg_     input      cfg_we             cfg_wdata (id_offset)
//
// A request that is answered without the bitmap (pool exhausted, reserved or
// out-of-range identifier) passes from S_START straight to S_HOLD, where its
// result is loaded. A free, or an allocation whose next free slot lies in the
// same word, passes through S_START, S_MOD and S_HOLD; an allocation that must
// search on also passes through S_SCAN once for each further bitmap word read,
// at most MAP_WORDS - 1 of them, through the single RAM read port.
// After reset a clearing pass marks every slot free, word by word; no request
// is accepted during it, while configuration writes are.
// A new request is accepted once the previous one has left the working
// states, even while its result still waits at a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_id_allocator_top #(
  parameter int POOL_SIZE = lfid_pkg::DEFAULT_POOL_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [lfid_pkg::ID_W-1:0]     in_release_id,

  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [lfid_pkg::ID_W-1:0]     out_granted_id,
  output logic      [2:0]                    out_status,

  input  wire logic                          cfg_we,
  input  wire logic [lfid_pkg::OFFSET_W-1:0] cfg_wdata
);

  localparam int WB        = lfid_pkg::WORD_BITS;
  localparam int BW        = lfid_pkg::BIT_IDX_W;
  localparam int ID_W      = lfid_pkg::ID_W;
  localparam int OFFSET_W  = lfid_pkg::OFFSET_W;
  localparam int MAP_WORDS = (POOL_SIZE + WB - 1) / WB;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  // A slot number runs from 1 to POOL_SIZE + 1, the latter meaning "none".
  localparam int SW        = $clog2(POOL_SIZE + 2);

  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [SW-1:0] NONE_FREE = SW'(POOL_SIZE + 1);
  localparam logic [SW-1:0] POOL_TOP  = SW'(POOL_SIZE);

  // The last word carries flags only for slots that exist; the rest stay
  // clear so that a search never finds them.
  localparam lfid_pkg::map_word_t LAST_MASK =
    (POOL_SIZE % WB == 0) ? '1 :
    ((lfid_pkg::map_word_t'(1) << (POOL_SIZE % WB)) - lfid_pkg::map_word_t'(1));

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;          // clear pass and search
  logic [SW-1:0]             lf_r, lf_nxt;              // lowest free slot
  logic [OFFSET_W-1:0]       offset_r;
  logic                      req_r;
  logic [ID_W-1:0]           rel_r;
  logic [SW-1:0]             bit_r, bit_nxt;            // slot - 1 being worked on
  logic [ID_W-1:0]           res_id_r, res_id_nxt;
  lfid_pkg::status_t         res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]           out_id_r;
  lfid_pkg::status_t         out_status_r;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  lfid_pkg::map_word_t       ram_wdata;
  logic [AW-1:0]             ram_raddr;
  lfid_pkg::map_word_t       ram_rdata;

  logic                      accept;
  logic                      out_free;
  logic                      load_out;

  // Decode of the latched request and of the word just read.
  logic [ID_W-1:0]           free_slot;
  logic [AW-1:0]             bit_word;
  logic [BW-1:0]             bit_pos;
  lfid_pkg::map_word_t       bit_mask;
  lfid_pkg::map_word_t       alloc_word;
  lfid_pkg::map_word_t       above;
  logic [SW-1:0]             work_slot;
  logic [SW-1:0]             mod_found;
  logic [SW-1:0]             scan_found;
  logic [ID_W:0]             grant_sum;

  lfid_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_HOLD) && out_free;

  assign free_slot  = rel_r - ID_W'(offset_r);
  assign bit_word   = AW'(bit_r >> BW);
  assign bit_pos    = bit_r[BW-1:0];
  assign bit_mask   = lfid_pkg::map_word_t'(1) << bit_pos;
  assign alloc_word = ram_rdata & ~bit_mask;
  // Flags at and above the slot just taken; those below are all in use.
  assign above      = alloc_word & ('1 << bit_pos);
  assign work_slot  = bit_r + SW'(1);
  assign mod_found  = SW'({1'b0, bit_word, lfid_pkg::first_set(above)}) + SW'(1);
  assign scan_found = SW'({1'b0, addr_r, lfid_pkg::first_set(ram_rdata)}) + SW'(1);
  assign grant_sum  = (ID_W + 1)'(work_slot) + (ID_W + 1)'(offset_r);

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    lf_nxt         = lf_r;
    bit_nxt        = bit_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    ram_we         = 1'b0;
    ram_waddr      = bit_word;
    ram_wdata      = alloc_word;
    ram_raddr      = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = (addr_r == LAST_WORD) ? LAST_MASK : '1;
        addr_nxt  = addr_r + AW'(1);
        if (addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_id_nxt     = '0;
        res_status_nxt = lfid_pkg::STATUS_OK;
        if (!req_r) begin
          if (lf_r > POOL_TOP) begin
            res_status_nxt = lfid_pkg::STATUS_EXHAUSTED;
            state_nxt      = S_HOLD;
          end else begin
            bit_nxt   = lf_r - SW'(1);
            ram_raddr = AW'((lf_r - SW'(1)) >> BW);
            state_nxt = S_MOD;
          end
        end else if (rel_r <= ID_W'(offset_r)) begin
          res_status_nxt = lfid_pkg::STATUS_RESERVED;
          state_nxt      = S_HOLD;
        end else if ({1'b0, free_slot} > (ID_W + 1)'(POOL_SIZE)) begin
          res_status_nxt = lfid_pkg::STATUS_RANGE;
          state_nxt      = S_HOLD;
        end else begin
          bit_nxt   = SW'(free_slot - ID_W'(1));
          ram_raddr = AW'((free_slot - ID_W'(1)) >> BW);
          state_nxt = S_MOD;
        end
      end

      S_MOD: begin
        if (!req_r) begin
          ram_we     = 1'b1;
          ram_wdata  = alloc_word;
          res_id_nxt = grant_sum[ID_W-1:0];
          priority if (|above) begin
            lf_nxt    = mod_found;
            state_nxt = S_HOLD;
          end else if (bit_word == LAST_WORD) begin
            lf_nxt    = NONE_FREE;
            state_nxt = S_HOLD;
          end else begin
            addr_nxt  = bit_word + AW'(1);
            ram_raddr = bit_word + AW'(1);
            state_nxt = S_SCAN;
          end
        end else begin
          state_nxt = S_HOLD;
          if (ram_rdata[bit_pos]) begin
            res_status_nxt = lfid_pkg::STATUS_DOUBLE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_mask;
            if (work_slot < lf_r) begin
              lf_nxt = work_slot;
            end
          end
        end
      end

      S_SCAN: begin
        // The read data belongs to the word at addr_r.
        priority if (|ram_rdata) begin
          lf_nxt    = scan_found;
          state_nxt = S_HOLD;
        end else if (addr_r == LAST_WORD) begin
          lf_nxt    = NONE_FREE;
          state_nxt = S_HOLD;
        end else begin
          addr_nxt  = addr_r + AW'(1);
          ram_raddr = addr_r + AW'(1);
        end
      end

      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      lf_r        <= SW'(1);
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      lf_r        <= lf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        offset_r <= cfg_wdata;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      rel_r <= in_release_id;
    end
    bit_r        <= bit_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_id_r     <= res_id_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted_id = out_id_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire
